/* hdl/edlp_pkg.sv */
// Shared types and constants for the escaped DSV line parser.
// Used by the step logic, the top level and the port checker.
package edlp_pkg;

  // Field limits
  localparam int MAX_FIELDS = 16;
  localparam int FIELD_W    = 5;   // current field counter, holds 0..MAX_FIELDS
  localparam int INDEX_W    = 4;   // field index reported with each result

  // Special characters
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_NL     = 8'h0A;

  // Result kinds
  localparam logic [1:0] KIND_DATA      = 2'd0;
  localparam logic [1:0] KIND_FIELD_END = 2'd1;
  localparam logic [1:0] KIND_LINE_END  = 2'd2;

  // Line status codes
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_EMPTY_LINE  = 3'd1;
  localparam logic [2:0] ST_EMPTY_FIELD = 3'd2;
  localparam logic [2:0] ST_TOO_MANY    = 3'd3;
  localparam logic [2:0] ST_TOO_FEW     = 3'd4;

  // Configuration register map (byte addresses)
  localparam int          PADDR_W      = 3;
  localparam logic [PADDR_W-1:0] ADDR_FIELD_COUNT = 3'd0;

  // Per-line parser state
  typedef struct packed {
    logic               escape_pending;
    logic [FIELD_W-1:0] current_field;
    logic               field_has_bytes;
    logic               line_has_bytes;
    logic [2:0]         line_error;
  } line_state_t;

  // One result word
  typedef struct packed {
    logic [1:0]         kind;
    logic [7:0]         out_char;
    logic [INDEX_W-1:0] field_index;
    logic [2:0]         status;
  } result_t;

endpackage

/* hdl/edlp_in_if.sv */
// Input channel of the escaped DSV line parser: one raw text byte per word.
// Valid/ready handshake; no dependencies.
interface edlp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

/* hdl/edlp_out_if.sv */
// Result channel of the escaped DSV line parser: kind, byte, field, status.
// Valid/ready handshake; no dependencies.
interface edlp_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] out_char;
  logic [3:0] field_index;
  logic [2:0] status;

  modport source (output valid, output kind, output out_char, output field_index,
                  output status, input ready);
  modport sink   (input valid, input kind, input out_char, input field_index,
                  input status, output ready);
endinterface

/* hdl/edlp_step.sv */
// Next-state and result logic for one raw byte of the parser.
// Depends on edlp_pkg.
module edlp_step import edlp_pkg::*; (
  input  line_state_t  cur,
  input  logic [7:0]   in_byte,
  input  logic [4:0]   field_count,
  output line_state_t  nxt,
  output result_t      res,
  output logic         res_valid
);

  logic [FIELD_W-1:0] cnt;
  logic [FIELD_W:0]   next_field;
  logic               too_few;
  logic [7:0]         data_byte;
  logic [2:0]         line_status;

  // Clamp the field count register to 1..MAX_FIELDS
  always_comb begin
    cnt = field_count;
    if (field_count == '0) begin
      cnt = FIELD_W'(1);
    end else if (field_count > FIELD_W'(MAX_FIELDS)) begin
      cnt = FIELD_W'(MAX_FIELDS);
    end
  end

  assign next_field = {1'b0, cur.current_field} + (FIELD_W+1)'(1);
  assign too_few    = next_field < {1'b0, cnt};
  assign data_byte  = (cur.escape_pending && in_byte == CH_N) ? CH_NL : in_byte;

  // Status reported at end of line, first matching condition wins
  always_comb begin
    if (cur.line_error != ST_OK) begin
      line_status = cur.line_error;
    end else if (!cur.line_has_bytes && !cur.escape_pending) begin
      line_status = ST_EMPTY_LINE;
    end else if (!cur.field_has_bytes) begin
      line_status = ST_EMPTY_FIELD;
    end else if (too_few) begin
      line_status = ST_TOO_FEW;
    end else begin
      line_status = ST_OK;
    end
  end

  // Byte classification and state update
  always_comb begin
    nxt             = cur;
    res_valid       = 1'b0;
    res.kind        = KIND_DATA;
    res.out_char    = '0;
    res.field_index = cur.current_field[INDEX_W-1:0];
    res.status      = ST_OK;

    if (in_byte == CH_NL) begin
      // raw newline always closes the line, pending escape dropped
      res_valid  = 1'b1;
      res.kind   = KIND_LINE_END;
      res.status = line_status;
      nxt        = '0;
    end else if (!cur.escape_pending && in_byte == CH_BSLASH) begin
      nxt.escape_pending = 1'b1;
    end else if (!cur.escape_pending && in_byte == CH_COLON) begin
      if (cur.line_error != ST_OK) begin
        // suppressed until newline
      end else if (!cur.field_has_bytes) begin
        nxt.line_error = ST_EMPTY_FIELD;
      end else begin
        res_valid = 1'b1;
        res.kind  = KIND_FIELD_END;
        if (cur.current_field < FIELD_W'(MAX_FIELDS)) begin
          nxt.current_field = next_field[FIELD_W-1:0];
        end
        nxt.field_has_bytes = 1'b0;
      end
    end else begin
      // data byte, escaped or not
      nxt.escape_pending = 1'b0;
      if (cur.line_error != ST_OK) begin
        // suppressed until newline
      end else if (cur.current_field >= cnt) begin
        nxt.line_error = ST_TOO_MANY;
      end else begin
        res_valid           = 1'b1;
        res.kind            = KIND_DATA;
        res.out_char        = data_byte;
        nxt.field_has_bytes = 1'b1;
        nxt.line_has_bytes  = 1'b1;
      end
    end
  end

endmodule

/* hdl/escaped_dsv_line_parser.sv */
// Top level of the escaped DSV line parser: state, output register, APB port.
// Depends on edlp_pkg, edlp_in_if, edlp_out_if and edlp_step.
//
// The parser takes one raw byte per clock on the text channel unless stalled
// and gives at most one result word per byte on the token channel, in the
// cycle after the byte is taken. Throughput is one byte per cycle without a
// stall, set by the combinational line state update in edlp_step; text.ready
// stays high while the output register is empty or is being drained in the
// same cycle. The field_count register sits at byte address 0 of the APB port
// and should be written only while the parser holds no pending result.
module escaped_dsv_line_parser import edlp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  edlp_in_if.sink            text,
  edlp_out_if.source         token,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  line_state_t state;
  line_state_t state_next;
  result_t     result;
  result_t     result_next;
  logic        result_valid_next;
  logic        out_valid;
  logic [4:0]  field_count;
  logic        accept;
  logic        cfg_write;
  logic        cfg_hit;

  // Register access
  assign pready    = 1'b1;
  assign cfg_hit   = paddr[PADDR_W-1:2] == ADDR_FIELD_COUNT[PADDR_W-1:2];
  assign cfg_write = psel && penable && pwrite && cfg_hit;
  assign prdata    = cfg_hit ? {27'd0, field_count} : 32'd0;

  // Input handshake
  assign text.ready = !out_valid || token.ready;
  assign accept     = text.valid && text.ready;

  edlp_step u_step (
    .cur         (state),
    .in_byte     (text.in_byte),
    .field_count (field_count),
    .nxt         (state_next),
    .res         (result_next),
    .res_valid   (result_valid_next)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= '0;
      field_count <= 5'd1;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_write) begin
        field_count <= pwdata[4:0];
      end
      if (accept) begin
        state     <= state_next;
        out_valid <= result_valid_next;
      end else if (token.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (accept && result_valid_next) begin
      result <= result_next;
    end
  end

  assign token.valid       = out_valid;
  assign token.kind        = result.kind;
  assign token.out_char    = result.out_char;
  assign token.field_index = result.field_index;
  assign token.status      = result.status;

endmodule

/* hdl/edlp_checker.sv */
// Port-level checks for the escaped DSV line parser, bound to the top level.
// Depends on edlp_pkg.
module edlp_checker import edlp_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] kind,
  input logic [7:0] out_char,
  input logic [3:0] field_index,
  input logic [2:0] status
);

  // Kind is one of the three defined codes
  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (kind == KIND_DATA || kind == KIND_FIELD_END || kind == KIND_LINE_END))
    else $error("illegal result kind");

  // Only line ends carry a status
  a_status_line_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind != KIND_LINE_END) |-> status == ST_OK)
    else $error("status on a non line-end result");

  // Only data words carry a byte
  a_char_data: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind != KIND_DATA) |-> out_char == 8'd0)
    else $error("byte on a non data result");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(kind) && $stable(out_char)
      && $stable(field_index) && $stable(status)))
    else $error("stalled result changed");

endmodule

bind escaped_dsv_line_parser edlp_checker u_edlp_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (token.valid),
  .out_ready   (token.ready),
  .kind        (token.kind),
  .out_char    (token.out_char),
  .field_index (token.field_index),
  .status      (token.status)
);
